// ===== hw/rtl/rcd_pkg.sv =====
`default_nettype none

package rcd_pkg;

    localparam int unsigned CFG_W   = 32;
    localparam int unsigned COUNT_W = 32;

    localparam logic [7:0] MARK_LITERAL = 8'h00;
    localparam logic [7:0] MARK_RUN     = 8'h01;

    localparam logic [2:0] ST_BUSY         = 3'd0;
    localparam logic [2:0] ST_DONE         = 3'd1;
    localparam logic [2:0] ST_SHORT_HEADER = 3'd2;
    localparam logic [2:0] ST_SHORT_DATA   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW     = 3'd4;
    localparam logic [2:0] ST_BAD_MARKER   = 3'd5;
    localparam logic [2:0] ST_SHORT_OUTPUT = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } rcd_in_t;

    typedef struct packed {
        logic               data_valid;
        logic [7:0]         out_byte;
        logic [COUNT_W-1:0] repeat_count;
        logic [2:0]         status;
    } rcd_out_t;

    // handshake between input stage and parse core
    typedef struct packed {
        logic    step;
        rcd_in_t item;
    } rcd_step_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcd_in_stage.sv =====
`default_nettype none

module rcd_in_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire rcd_pkg::rcd_in_t s_data,
    input  wire logic             out_free,
    output rcd_pkg::rcd_step_t    step_o
);
    import rcd_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    rcd_in_t in_item_reg;
    logic    advance;

    // held item moves on when the result register can take its outcome
    assign advance       = in_valid_reg && out_free;
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    assign step_o.step = advance;
    assign step_o.item = in_item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rcd_parse_core.sv =====
`default_nettype none

module rcd_parse_core #(
    parameter int unsigned POS_W = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire rcd_pkg::rcd_step_t          step_i,
    input  wire logic [rcd_pkg::CFG_W-1:0]   expected_out_size,
    output rcd_pkg::rcd_out_t                result_o,
    output logic                             result_present
);
    import rcd_pkg::*;

    localparam int unsigned SUM_W = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

    typedef enum logic [5:0] {
        PH_MARKER     = 6'b000001,
        PH_HEADER     = 6'b000010,
        PH_HEADER_BAD = 6'b000100,
        PH_VALUE      = 6'b001000,
        PH_LITERAL    = 6'b010000,
        PH_DONE       = 6'b100000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [1:0]         hdr_idx_reg, hdr_idx_next;
    logic               is_run_reg, is_run_next;
    logic [COUNT_W-1:0] chunk_count_reg, chunk_count_next;
    logic [COUNT_W-1:0] literal_left_reg, literal_left_next;
    logic [POS_W-1:0]   position_reg, position_next;

    logic [POS_W-1:0]   limit;
    logic [SUM_W-1:0]   limit_ext;
    logic [SUM_W-1:0]   pos_ext;
    logic [COUNT_W-1:0] full_count;
    logic [COUNT_W-1:0] add_operand;
    logic [SUM_W-1:0]   pos_sum;
    logic [SUM_W-1:0]   pos_inc;
    logic [2:0]         status;
    logic               dvalid;
    logic [7:0]         obyte;
    logic [COUNT_W-1:0] rep;

    function automatic logic [2:0] boundary(input logic [SUM_W-1:0] pos,
                                            input logic [SUM_W-1:0] lim);
        if (pos == lim) begin
            return ST_DONE;
        end else if (pos > lim) begin
            return ST_OVERFLOW;
        end else begin
            return ST_BUSY;
        end
    endfunction

    generate
        if (POS_W >= CFG_W) begin : g_lim_wide
            assign limit = POS_W'(expected_out_size);
        end else begin : g_lim_narrow
            assign limit = expected_out_size[POS_W-1:0];
        end
    endgenerate

    assign limit_ext   = SUM_W'(limit);
    assign pos_ext     = SUM_W'(position_reg);
    assign full_count  = {step_i.item.data_byte, chunk_count_reg[23:0]};
    // one adder serves the literal header check and the run value check
    assign add_operand = (phase_reg == PH_VALUE) ? chunk_count_reg : full_count;
    assign pos_sum     = pos_ext + SUM_W'(add_operand);
    assign pos_inc     = pos_ext + SUM_W'(1);

    always_comb begin
        phase_next        = phase_reg;
        hdr_idx_next      = hdr_idx_reg;
        is_run_next       = is_run_reg;
        chunk_count_next  = chunk_count_reg;
        literal_left_next = literal_left_reg;
        position_next     = position_reg;
        status            = ST_BUSY;
        dvalid            = 1'b0;
        obyte             = 8'd0;
        rep               = '0;
        result_present    = 1'b0;

        if (step_i.step && phase_reg != PH_DONE) begin
            case (phase_reg)
                PH_MARKER: begin
                    status = boundary(pos_ext, limit_ext);
                    if (status == ST_BUSY) begin
                        if (step_i.item.data_byte == MARK_RUN) begin
                            phase_next  = PH_HEADER;
                            is_run_next = 1'b1;
                        end else if (step_i.item.data_byte == MARK_LITERAL) begin
                            phase_next  = PH_HEADER;
                            is_run_next = 1'b0;
                        end else begin
                            phase_next  = PH_HEADER_BAD;
                            is_run_next = 1'b0;
                        end
                        hdr_idx_next     = 2'd0;
                        chunk_count_next = '0;
                    end
                end
                PH_HEADER, PH_HEADER_BAD: begin
                    chunk_count_next[8*hdr_idx_reg +: 8] = step_i.item.data_byte;
                    if (hdr_idx_reg != 2'd3) begin
                        hdr_idx_next = hdr_idx_reg + 2'd1;
                    end else begin
                        hdr_idx_next = 2'd0;
                        if (phase_reg == PH_HEADER_BAD) begin
                            status = ST_BAD_MARKER;
                        end else if (is_run_reg) begin
                            phase_next = PH_VALUE;
                        end else if (pos_sum > limit_ext) begin
                            status = ST_OVERFLOW;
                        end else if (full_count == '0) begin
                            phase_next = PH_MARKER;
                            status     = boundary(pos_ext, limit_ext);
                        end else begin
                            literal_left_next = full_count;
                            phase_next        = PH_LITERAL;
                        end
                    end
                end
                PH_VALUE: begin
                    if (pos_sum > limit_ext) begin
                        status = ST_OVERFLOW;
                    end else begin
                        if (chunk_count_reg != '0) begin
                            dvalid = 1'b1;
                            obyte  = step_i.item.data_byte;
                            rep    = chunk_count_reg;
                        end
                        // sum stays within limit, so it fits the position width
                        position_next = pos_sum[POS_W-1:0];
                        phase_next    = PH_MARKER;
                        status        = boundary(pos_sum, limit_ext);
                    end
                end
                PH_LITERAL: begin
                    dvalid        = 1'b1;
                    obyte         = step_i.item.data_byte;
                    rep           = COUNT_W'(1);
                    position_next = pos_inc[POS_W-1:0];
                    if (literal_left_reg != '0) begin
                        literal_left_next = literal_left_reg - COUNT_W'(1);
                    end
                    if (literal_left_reg <= COUNT_W'(1)) begin
                        phase_next = PH_MARKER;
                        status     = boundary(pos_inc, limit_ext);
                    end
                end
                default: begin
                end
            endcase

            if (status == ST_BUSY && step_i.item.last_byte) begin
                if (phase_next == PH_HEADER || phase_next == PH_HEADER_BAD) begin
                    status = ST_SHORT_HEADER;
                end else if (phase_next == PH_VALUE || phase_next == PH_LITERAL) begin
                    status = ST_SHORT_DATA;
                end else begin
                    status = ST_SHORT_OUTPUT;
                end
            end
            if (status != ST_BUSY) begin
                phase_next = PH_DONE;
            end
            result_present = dvalid || (status != ST_BUSY);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_MARKER;
            hdr_idx_reg      <= 2'd0;
            is_run_reg       <= 1'b0;
            chunk_count_reg  <= '0;
            literal_left_reg <= '0;
            position_reg     <= '0;
        end else begin
            phase_reg        <= phase_next;
            hdr_idx_reg      <= hdr_idx_next;
            is_run_reg       <= is_run_next;
            chunk_count_reg  <= chunk_count_next;
            literal_left_reg <= literal_left_next;
            position_reg     <= position_next;
        end
    end

    assign result_o.data_valid   = dvalid;
    assign result_o.out_byte     = obyte;
    assign result_o.repeat_count = rep;
    assign result_o.status       = status;

endmodule

`default_nettype wire

// ===== hw/rtl/rle_chunk_decoder.sv =====
`default_nettype none

// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  rcd_in_t  (data_byte, last_byte)
// m_        out        m_valid / m_ready  rcd_out_t (data_valid, out_byte, repeat_count, status)
// cfg_      in         cfg_valid / cfg_ready  expected_out_size (32 bits)
//
// one compressed byte per cycle while the output register drains; an accepted item is
// decoded while it sits in the input register, and its result enters the output register
// at the edge that moves the item on; the rate is otherwise set by the parse state loop
// reset returns the parse state to the marker phase and clears the output position and the size register to zero
// a full output register that is not drained holds the input register, even for an
// item with no result, and s_ready drops once that register is full

module rle_chunk_decoder #(
    parameter int unsigned POSITION_WIDTH = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // compressed byte items
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire rcd_pkg::rcd_in_t           s_data,
    // decoded result items
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output rcd_pkg::rcd_out_t               m_data,
    // expected output size register
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [rcd_pkg::CFG_W-1:0]  cfg_data
);
    import rcd_pkg::*;

    logic [CFG_W-1:0] expected_out_size_reg;
    logic             m_valid_reg, m_valid_next;
    rcd_out_t         m_data_reg;
    rcd_step_t        step;
    rcd_out_t         result;
    logic             result_present;
    logic             out_free;

    // size register takes a write in any cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_out_size_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            expected_out_size_reg <= cfg_data;
        end
    end

    // output register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;

    rcd_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .out_free (out_free),
        .step_o   (step)
    );

    rcd_parse_core #(
        .POS_W (POSITION_WIDTH)
    ) u_parse_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step_i            (step),
        .expected_out_size (expected_out_size_reg),
        .result_o          (result),
        .result_present    (result_present)
    );

    // a stepped item loads its result, or empties the register when it has none
    assign m_valid_next = step.step ? result_present : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step.step && result_present) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
    import rcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int RAND_ITEMS   = 1150;
    localparam int SETTLE       = 8;          // pipeline depth plus margin before a size write
    localparam int TAIL_CYCLES  = 20;
    localparam int LIMIT_CYCLES = 400000;
    localparam longint unsigned HEADROOM = 64'h0400_0000;

    localparam rcd_out_t NO_RESULT = '0;

    // parser phases of the decoder
    typedef enum logic [2:0] {
        PARSE_MARKER,
        PARSE_HDR,
        PARSE_HDR_BAD,
        PARSE_VALUE,
        PARSE_LITERAL
    } parse_phase_e;

    // directed table row kinds
    typedef enum logic [1:0] {
        ROW_CFG,     // write the expected size register
        ROW_BYTE,    // send a byte, result from the decode model
        ROW_CHECK    // send a byte, result typed in the row
    } row_kind_e;

    // how the single stream of the run is brought to its end
    typedef enum int {
        END_DONE_RUN,
        END_DONE_MARK,
        END_OVF_LIT,
        END_OVF_RUN,
        END_BAD_MARK,
        END_SHORT_HDR,
        END_SHORT_DATA,
        END_SHORT_OUT,
        END_BEYOND
    } ending_e;

    typedef struct {
        row_kind_e  kind;
        logic [31:0] value;
        logic        last;
        rcd_out_t    result;
    } dir_row_t;

    // clock, reset and block ports, the driven ones known from time zero
    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    rcd_in_t  s_data    = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    rcd_out_t m_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;

    // decode model state
    parse_phase_e    dec_phase   = PARSE_MARKER;
    logic [1:0]      dec_hdr_idx = '0;
    logic            dec_is_run  = 1'b0;
    logic [31:0]     dec_count   = '0;
    logic [31:0]     dec_lit_left = '0;
    longint unsigned dec_pos     = 0;
    logic            dec_done    = 1'b0;
    logic [31:0]     size_reg    = '0;

    rcd_out_t pending_results[$];
    rcd_out_t want_item;
    int       errors      = 0;
    int       items_sent  = 0;
    int       send_calm   = 0;
    int       recv_calm   = 0;
    int       stall_left  = 0;

    // directed stimulus: both size extremes, literal extremes, zero counts, a wide run
    dir_row_t dir_table [26] = '{
        '{ROW_CFG,   32'h0000_0000, 1'b0, NO_RESULT},
        '{ROW_CFG,   32'hFFFF_FFFF, 1'b0, NO_RESULT},
        // literal of two bytes, both data extremes
        '{ROW_BYTE,  32'(MARK_LITERAL), 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'h02, 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'h00, 1'b0, NO_RESULT},
        '{ROW_CHECK, 32'h00, 1'b0, '{1'b1, 8'h00, 32'd1, ST_BUSY}},
        '{ROW_CHECK, 32'hFF, 1'b0, '{1'b1, 8'hFF, 32'd1, ST_BUSY}},
        // zero-length literal
        '{ROW_BYTE,  32'(MARK_LITERAL), 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'h00, 1'b0, NO_RESULT},
        // run of zero copies
        '{ROW_BYTE,  32'(MARK_RUN), 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'h00, 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'h5A, 1'b0, NO_RESULT},
        // wide run, count bytes ff ff ff 01
        '{ROW_BYTE,  32'(MARK_RUN), 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'hFF, 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'hFF, 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'hFF, 1'b0, NO_RESULT},
        '{ROW_BYTE,  32'h01, 1'b0, NO_RESULT},
        '{ROW_CHECK, 32'hA5, 1'b0, '{1'b1, 8'hA5, 32'h01FF_FFFF, ST_BUSY}}
    };

    rle_chunk_decoder #(
        .POSITION_WIDTH (32)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // idle length: mostly none or short, a few long, and calm stretches with no idling
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(40, 160);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // position versus expected size at a chunk boundary
    function automatic logic [2:0] size_check();
        if (dec_pos == 64'(size_reg)) return ST_DONE;
        if (dec_pos > 64'(size_reg)) return ST_OVERFLOW;
        return ST_BUSY;
    endfunction

    // decode one accepted byte, update model state, give the result item if any
    task automatic decode_step(input rcd_in_t it, output bit has, output rcd_out_t res);
        logic [2:0]  st;
        logic        is_last;
        logic        dv;
        logic [7:0]  ob;
        logic [31:0] rep;
        has = 1'b0;
        res = NO_RESULT;
        st = ST_BUSY;
        is_last = it.last_byte;
        dv = 1'b0;
        ob = '0;
        rep = '0;
        if (dec_done) return;   // everything after a final status is dropped
        case (dec_phase)
            PARSE_MARKER: begin
                st = size_check();
                if (st != ST_BUSY) begin
                    is_last = 1'b0;     // byte at a marker slot is swallowed by the check
                end else begin
                    if (it.data_byte == MARK_RUN) begin
                        dec_phase = PARSE_HDR;
                        dec_is_run = 1'b1;
                    end else if (it.data_byte == MARK_LITERAL) begin
                        dec_phase = PARSE_HDR;
                        dec_is_run = 1'b0;
                    end else begin
                        dec_phase = PARSE_HDR_BAD;
                        dec_is_run = 1'b0;
                    end
                    dec_hdr_idx = '0;
                    dec_count = '0;
                end
            end
            PARSE_HDR, PARSE_HDR_BAD: begin
                dec_count = dec_count | (32'(it.data_byte) << (8 * dec_hdr_idx));
                if (dec_hdr_idx < 2'd3) begin
                    dec_hdr_idx = dec_hdr_idx + 2'd1;
                end else begin
                    dec_hdr_idx = '0;
                    if (dec_phase == PARSE_HDR_BAD) begin
                        st = ST_BAD_MARKER;
                    end else if (dec_is_run) begin
                        dec_phase = PARSE_VALUE;
                    end else if (dec_pos + 64'(dec_count) > 64'(size_reg)) begin
                        st = ST_OVERFLOW;
                    end else if (dec_count == 0) begin
                        dec_phase = PARSE_MARKER;
                        st = size_check();
                    end else begin
                        dec_lit_left = dec_count;
                        dec_phase = PARSE_LITERAL;
                    end
                end
            end
            PARSE_VALUE: begin
                if (dec_pos + 64'(dec_count) > 64'(size_reg)) begin
                    st = ST_OVERFLOW;
                end else begin
                    if (dec_count != 0) begin
                        dv = 1'b1;
                        ob = it.data_byte;
                        rep = dec_count;
                    end
                    dec_pos = dec_pos + 64'(dec_count);
                    dec_phase = PARSE_MARKER;
                    st = size_check();
                end
            end
            default: begin
                dv = 1'b1;
                ob = it.data_byte;
                rep = 32'd1;
                dec_pos = dec_pos + 1;
                if (dec_lit_left > 0) dec_lit_left = dec_lit_left - 1;
                if (dec_lit_left == 0) begin
                    dec_phase = PARSE_MARKER;
                    st = size_check();
                end
            end
        endcase
        // stream ended before the output was complete
        if (st == ST_BUSY && is_last) begin
            if (dec_phase == PARSE_HDR || dec_phase == PARSE_HDR_BAD) st = ST_SHORT_HEADER;
            else if (dec_phase == PARSE_VALUE || dec_phase == PARSE_LITERAL) st = ST_SHORT_DATA;
            else st = ST_SHORT_OUTPUT;
        end
        if (st != ST_BUSY) dec_done = 1'b1;
        has = dv || (st != ST_BUSY);
        res = '{dv, ob, rep, st};
    endtask

    // one byte item on the input channel, model updated at acceptance
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input bit typed, input rcd_out_t typed_res);
        int       gap;
        bit       has;
        rcd_out_t res;
        gap = idle_len(send_calm);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, last_byte: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        decode_step('{data_byte: b, last_byte: last}, has, res);
        if (typed) pending_results.push_back(typed_res);
        else if (has) pending_results.push_back(res);
    endtask

    // marker plus little-endian 32-bit count
    task automatic send_header(input logic [7:0] marker, input logic [31:0] cnt);
        send_byte(marker, 1'b0, 1'b0, NO_RESULT);
        for (int i = 0; i < 4; i++) send_byte(cnt[8*i +: 8], 1'b0, 1'b0, NO_RESULT);
    endtask

    // size register write, only once the decoder has gone quiet
    task automatic write_size(input logic [31:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        size_reg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // result side: random back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            stall_left <= idle_len(recv_calm);
        end
    end

    // compare every accepted result item with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: %p", m_data);
                errors++;
            end else begin
                want_item = pending_results.pop_front();
                check_field("data_valid", 32'(want_item.data_valid), 32'(m_data.data_valid));
                check_field("out_byte", 32'(want_item.out_byte), 32'(m_data.out_byte));
                check_field("repeat_count", want_item.repeat_count, m_data.repeat_count);
                check_field("status", 32'(want_item.status), 32'(m_data.status));
            end
        end
    end

    // hard stop for a hung run
    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("rle_chunk_decoder test failed");
        $finish;
    end

    // stimulus
    initial begin
        logic [31:0]     cnt;
        logic [31:0]     v;
        longint unsigned lo;
        longint unsigned room;
        int              pick;
        int              k;
        ending_e         how;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_CFG) begin
                write_size(dir_table[i].value);
            end else begin
                send_byte(dir_table[i].value[7:0], dir_table[i].last,
                          dir_table[i].kind == ROW_CHECK, dir_table[i].result);
            end
        end

        // random well-formed chunks in one long stream, size moved now and then
        while (items_sent < RAND_ITEMS + 24) begin
            if ($urandom_range(0, 9) == 0) begin
                lo = dec_pos + HEADROOM;
                v = $urandom_range(32'hFFFF_FFFF, 32'(lo));
                write_size(v);
            end
            room = 64'(size_reg) - dec_pos;
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 1) == 1) begin
                // run chunk
                if (pick < 8) cnt = 0;
                else if (pick < 85) cnt = $urandom_range(1, 300);
                else cnt = $urandom_range(301, 32'h000F_FFFF);
                if (64'(cnt) >= room) cnt = 0;    // never reach the size mid-stream
                send_header(MARK_RUN, cnt);
                send_byte(8'($urandom), 1'b0, 1'b0, NO_RESULT);
            end else begin
                // literal chunk
                if (pick < 10) cnt = 0;
                else if (pick < 90) cnt = $urandom_range(1, 8);
                else cnt = $urandom_range(9, 24);
                if (64'(cnt) >= room) cnt = 0;
                send_header(MARK_LITERAL, cnt);
                for (int i = 0; i < int'(cnt); i++) send_byte(8'($urandom), 1'b0, 1'b0, NO_RESULT);
            end
        end

        // the stream gets one final status per run, picked at random
        how = ending_e'($urandom_range(0, 8));
        case (how)
            END_DONE_RUN: begin
                cnt = $urandom_range(1, 1000);
                write_size(32'(dec_pos + 64'(cnt)));
                send_header(MARK_RUN, cnt);
                send_byte(8'($urandom), 1'($urandom), 1'b0, NO_RESULT);
            end
            END_DONE_MARK: begin
                // size met at a marker slot, byte dropped
                write_size(32'(dec_pos));
                send_byte(8'($urandom), 1'($urandom), 1'b0, NO_RESULT);
            end
            END_OVF_LIT: begin
                write_size(32'(dec_pos + 2));
                send_header(MARK_LITERAL, 32'd5);
            end
            END_OVF_RUN: begin
                write_size(32'hFFFF_FFFF);
                send_header(MARK_RUN, 32'hFFFF_FFFF);
                send_byte(8'($urandom), 1'b0, 1'b0, NO_RESULT);
            end
            END_BAD_MARK: begin
                send_header(8'($urandom_range(2, 255)), $urandom);
            end
            END_SHORT_HDR: begin
                // header cut after k count bytes, last flag on the final one
                k = $urandom_range(0, 3);
                send_byte(8'($urandom), k == 0, 1'b0, NO_RESULT);
                for (int i = 1; i <= k; i++) send_byte(8'($urandom), i == k, 1'b0, NO_RESULT);
            end
            END_SHORT_DATA: begin
                if ($urandom_range(0, 1) == 1) begin
                    // stream ends right after a run header, value missing
                    cnt = $urandom_range(1, 50);
                    send_byte(MARK_RUN, 1'b0, 1'b0, NO_RESULT);
                    for (int i = 0; i < 4; i++) send_byte(cnt[8*i +: 8], i == 3, 1'b0, NO_RESULT);
                end else begin
                    // literal cut short, bytes already passed on stay passed on
                    k = $urandom_range(0, 3);
                    send_header(MARK_LITERAL, 32'(k + 2));
                    for (int i = 0; i <= k; i++) send_byte(8'($urandom), i == k, 1'b0, NO_RESULT);
                end
            end
            END_SHORT_OUT: begin
                send_header(MARK_RUN, $urandom_range(1, 50));
                send_byte(8'($urandom), 1'b1, 1'b0, NO_RESULT);
            end
            default: begin
                // size lowered to zero, at or below the position
                write_size(32'h0000_0000);
                send_byte(8'($urandom), 1'($urandom), 1'b0, NO_RESULT);
            end
        endcase

        // bytes after the final status must all be dropped
        repeat (12) send_byte(8'($urandom), 1'($urandom), 1'b0, NO_RESULT);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("rle_chunk_decoder test passed");
        end else begin
            $display("rle_chunk_decoder test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
